// ===== rtl/core/pfse_pkg.sv =====
// shared types, constants and helper functions of the packet field step engine
`timescale 1ns / 1ps
package pfse_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
  localparam int ENT_W          = $clog2(TABLE_DEPTH + 1);
  localparam int BUFFER_BYTES   = 2048;
  localparam int BUF_AW         = $clog2(BUFFER_BYTES);
  localparam int BIDX_W         = BUF_AW + 1;
  localparam int MAX_FIELD_BITS = 64;
  localparam int WIN_BYTES      = MAX_FIELD_BITS / 8 + 1;
  localparam int WIN_BITS       = WIN_BYTES * 8;
  localparam int SH_W           = $clog2(WIN_BITS);
  localparam int SLOT_W         = $clog2(WIN_BYTES + 1);
  localparam int OFF_W          = 14;
  localparam int WID_W          = 7;
  localparam int CNT_W          = 7;

  localparam logic [ENT_W-1:0]  ENT_END   = ENT_W'(TABLE_DEPTH);
  localparam logic [BIDX_W-1:0] BUF_LIMIT = BIDX_W'(BUFFER_BYTES);
  localparam logic [WID_W-1:0]  WID_MAX   = WID_W'(MAX_FIELD_BITS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WIN_BYTES - 1);

  localparam logic [1:0] MODE_INC = 2'd1;
  localparam logic [1:0] MODE_DEC = 2'd2;

  typedef enum logic [1:0] {
    KIND_WR_DESC = 2'd0,
    KIND_WR_BYTE = 2'd1,
    KIND_RD_BYTE = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE_RD,
    ST_DESC_RD,
    ST_DESC_CHK,
    ST_FLD_RD,
    ST_FLD_LAST,
    ST_FLD_EXT,
    ST_FLD_STEP,
    ST_FLD_MRG,
    ST_FLD_WR
  } state_e;

  typedef struct packed {
    logic             used;
    logic [OFF_W-1:0] offset;
    logic [WID_W-1:0] width;
    logic [1:0]       mode;
  } desc_t;

  typedef struct packed {
    logic             shift_in;
    logic             extract;
    logic             step;
    logic             merge;
    logic             shift_out;
    logic             up;
    logic [2:0]       bit_ofs;
    logic [WID_W-1:0] width;
  } fu_ctrl_t;

  function automatic logic [MAX_FIELD_BITS-1:0] field_mask(input logic [WID_W-1:0] w);
    field_mask = ~({MAX_FIELD_BITS{1'b1}} << w);
  endfunction

  function automatic logic [SH_W-1:0] shift_amount(input logic [2:0] s,
                                                   input logic [WID_W-1:0] w);
    shift_amount = SH_W'(WIN_BITS) - SH_W'(s) - SH_W'(w);
  endfunction

  function automatic logic [SLOT_W-1:0] byte_span(input logic [2:0] s,
                                                  input logic [WID_W-1:0] w);
    logic [WID_W:0] bits;
    bits = (WID_W + 1)'(s) + (WID_W + 1)'(w) + (WID_W + 1)'(7);
    byte_span = SLOT_W'(bits >> 3);
  endfunction

endpackage

// ===== rtl/core/pfse_desc_mem.sv =====
// descriptor table memory with per-entry valid bits cleared at reset
`timescale 1ns / 1ps
module pfse_desc_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [pfse_pkg::TABLE_AW-1:0] waddr_i,
  input  pfse_pkg::desc_t              wdata_i,
  input  logic                         re_i,
  input  logic [pfse_pkg::TABLE_AW-1:0] raddr_i,
  output pfse_pkg::desc_t              rdata_o
);

  pfse_pkg::desc_t                    mem_q [pfse_pkg::TABLE_DEPTH];
  logic [pfse_pkg::TABLE_DEPTH-1:0]   vld_q;
  pfse_pkg::desc_t                    rd_q;
  logic                               rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

// ===== rtl/core/pfse_pkt_mem.sv =====
// packet byte buffer, one write and one registered read port
`timescale 1ns / 1ps
module pfse_pkt_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [pfse_pkg::BUF_AW-1:0] waddr_i,
  input  logic [7:0]                  wdata_i,
  input  logic                        re_i,
  input  logic [pfse_pkg::BUF_AW-1:0] raddr_i,
  output logic [7:0]                  rdata_o
);

  logic [7:0] mem_q [pfse_pkg::BUFFER_BYTES];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

// ===== rtl/core/pfse_field_unit.sv =====
// byte window, field extract, increment or decrement, and merge back
`timescale 1ns / 1ps
module pfse_field_unit (
  input  logic               clk_i,
  input  pfse_pkg::fu_ctrl_t ctrl_i,
  input  logic [7:0]         byte_i,
  output logic [7:0]         byte_o
);

  logic [pfse_pkg::WIN_BITS-1:0]       win_q, win_d;
  logic [pfse_pkg::MAX_FIELD_BITS-1:0] val_q, val_d;
  logic [pfse_pkg::MAX_FIELD_BITS-1:0] mask;
  logic [pfse_pkg::SH_W-1:0]           sh;
  logic [pfse_pkg::WIN_BITS-1:0]       shr;
  logic [pfse_pkg::WIN_BITS-1:0]       mask_w;
  logic [pfse_pkg::WIN_BITS-1:0]       val_w;

  always_comb begin
    mask   = pfse_pkg::field_mask(ctrl_i.width);
    sh     = pfse_pkg::shift_amount(ctrl_i.bit_ofs, ctrl_i.width);
    shr    = win_q >> sh;
    mask_w = {{(pfse_pkg::WIN_BITS - pfse_pkg::MAX_FIELD_BITS){1'b0}}, mask} << sh;
    val_w  = {{(pfse_pkg::WIN_BITS - pfse_pkg::MAX_FIELD_BITS){1'b0}}, val_q} << sh;
    win_d  = win_q;
    val_d  = val_q;
    if (ctrl_i.shift_in) begin
      win_d = {win_q[pfse_pkg::WIN_BITS-9:0], byte_i};
    end else if (ctrl_i.shift_out) begin
      win_d = {win_q[pfse_pkg::WIN_BITS-9:0], 8'h00};
    end else if (ctrl_i.merge) begin
      win_d = (win_q & ~mask_w) | val_w;
    end
    if (ctrl_i.extract) begin
      val_d = shr[pfse_pkg::MAX_FIELD_BITS-1:0] & mask;
    end else if (ctrl_i.step) begin
      val_d = (ctrl_i.up ? val_q + 1'b1 : val_q - 1'b1) & mask;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    val_q <= val_d;
  end

  assign byte_o = win_q[pfse_pkg::WIN_BITS-1 -: 8];

endmodule

// ===== rtl/core/packet_field_step_engine.sv =====
// top level: command sequencer of the packet field step engine
//
// Commands come in on start/busy: a command transfers at a rising edge with
// start high and busy low. kind_i selects write descriptor, write byte, read
// byte or advance; the other inputs carry that command's fields.
// Each command gives exactly one result, shown for one cycle with done_o high:
// read_byte_o for a byte read, fields_stepped_o for an advance, zero otherwise.
// The receiver cannot stall; done_o is never held.
// Descriptor and byte writes report from the done register set at the transfer;
// a byte read first reads the registered buffer, then reports. Advance reads
// and checks each descriptor walked, the unused one that ends the walk
// included, and stops when the walk runs past the last entry; each field
// stepped reads its window, extracts, steps and merges the field, and writes
// back the bytes it touches (1 to 9); the count is reported last.
// The packet buffer has one read and one write port: each field reads a
// nine-byte window one byte a cycle, modifies it and writes its bytes back.
// One command is worked on at a time; a command may follow a write command
// in the next cycle.
// Reset marks all descriptors unused at once; no clearing pass is needed.
// Packet bytes hold nothing defined until written.
`timescale 1ns / 1ps
module packet_field_step_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind_i,
  input  logic [5:0]                 entry_index_i,
  input  logic                       entry_used_i,
  input  logic [pfse_pkg::OFF_W-1:0] field_bit_offset_i,
  input  logic [pfse_pkg::WID_W-1:0] field_bit_width_i,
  input  logic [1:0]                 step_mode_i,
  input  logic [10:0]                byte_address_i,
  input  logic [7:0]                 byte_value_i,
  output logic                       done_o,
  output logic [7:0]                 read_byte_o,
  output logic [pfse_pkg::CNT_W-1:0] fields_stepped_o
);

  pfse_pkg::state_e state_q, state_d;

  logic [pfse_pkg::ENT_W-1:0]  entry_q, entry_d;
  logic [pfse_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pfse_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [pfse_pkg::SLOT_W-1:0] nbytes_q, nbytes_d;
  logic [pfse_pkg::BUF_AW-1:0] base_q, base_d;
  logic [2:0]                  bofs_q, bofs_d;
  logic [pfse_pkg::WID_W-1:0]  wid_q, wid_d;
  logic                        up_q, up_d;
  logic                        pend_q, pend_d;
  logic                        pend_ok_q, pend_ok_d;
  logic                        done_q, done_d;
  logic [7:0]                  rbyte_q, rbyte_d;
  logic [pfse_pkg::CNT_W-1:0]  stepped_q, stepped_d;

  logic                        desc_we, desc_re;
  pfse_pkg::desc_t             desc_wdata, desc_rdata;
  logic                        pkt_we, pkt_re;
  logic [pfse_pkg::BUF_AW-1:0] pkt_waddr, pkt_raddr;
  logic [7:0]                  pkt_wdata, pkt_rdata;
  logic [pfse_pkg::BIDX_W-1:0] fidx;
  logic                        fidx_ok;
  logic [pfse_pkg::WID_W-1:0]  wclamp;
  pfse_pkg::fu_ctrl_t          fu_ctrl;
  logic [7:0]                  fu_byte_in, fu_byte_out;

  assign fidx    = {1'b0, base_q} + pfse_pkg::BIDX_W'(slot_q);
  assign fidx_ok = fidx < pfse_pkg::BUF_LIMIT;
  assign wclamp  = (desc_rdata.width > pfse_pkg::WID_MAX) ? pfse_pkg::WID_MAX
                                                          : desc_rdata.width;

  assign desc_wdata = '{used: entry_used_i, offset: field_bit_offset_i,
                        width: field_bit_width_i, mode: step_mode_i};
  assign fu_byte_in = pend_ok_q ? pkt_rdata : 8'h00;

  always_comb begin
    state_d    = state_q;
    entry_d    = entry_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    nbytes_d   = nbytes_q;
    base_d     = base_q;
    bofs_d     = bofs_q;
    wid_d      = wid_q;
    up_d       = up_q;
    pend_d     = 1'b0;
    pend_ok_d  = 1'b0;
    done_d     = 1'b0;
    rbyte_d    = 8'h00;
    stepped_d  = '0;
    desc_we    = 1'b0;
    desc_re    = 1'b0;
    pkt_we     = 1'b0;
    pkt_re     = 1'b0;
    pkt_waddr  = fidx[pfse_pkg::BUF_AW-1:0];
    pkt_raddr  = fidx[pfse_pkg::BUF_AW-1:0];
    pkt_wdata  = fu_byte_out;
    fu_ctrl           = '0;
    fu_ctrl.shift_in  = pend_q;
    fu_ctrl.up        = up_q;
    fu_ctrl.bit_ofs   = bofs_q;
    fu_ctrl.width     = wid_q;
    case (state_q)
      pfse_pkg::ST_IDLE: begin
        pkt_waddr = byte_address_i;
        pkt_raddr = byte_address_i;
        pkt_wdata = byte_value_i;
        if (start) begin
          case (pfse_pkg::kind_e'(kind_i))
            pfse_pkg::KIND_WR_DESC: begin
              desc_we = 1'b1;
              done_d  = 1'b1;
            end
            pfse_pkg::KIND_WR_BYTE: begin
              pkt_we = 1'b1;
              done_d = 1'b1;
            end
            pfse_pkg::KIND_RD_BYTE: begin
              pkt_re  = 1'b1;
              state_d = pfse_pkg::ST_BYTE_RD;
            end
            pfse_pkg::KIND_ADVANCE: begin
              entry_d = '0;
              cnt_d   = '0;
              state_d = pfse_pkg::ST_DESC_RD;
            end
            default: begin
              state_d = pfse_pkg::ST_IDLE;
            end
          endcase
        end
      end
      pfse_pkg::ST_BYTE_RD: begin
        done_d  = 1'b1;
        rbyte_d = pkt_rdata;
        state_d = pfse_pkg::ST_IDLE;
      end
      pfse_pkg::ST_DESC_RD: begin
        if (entry_q == pfse_pkg::ENT_END) begin
          done_d    = 1'b1;
          stepped_d = cnt_q;
          state_d   = pfse_pkg::ST_IDLE;
        end else begin
          desc_re = 1'b1;
          state_d = pfse_pkg::ST_DESC_CHK;
        end
      end
      pfse_pkg::ST_DESC_CHK: begin
        if (!desc_rdata.used) begin
          done_d    = 1'b1;
          stepped_d = cnt_q;
          state_d   = pfse_pkg::ST_IDLE;
        end else if (wclamp == '0 || (desc_rdata.mode != pfse_pkg::MODE_INC &&
                                      desc_rdata.mode != pfse_pkg::MODE_DEC)) begin
          entry_d = entry_q + 1'b1;
          state_d = pfse_pkg::ST_DESC_RD;
        end else begin
          base_d   = desc_rdata.offset[pfse_pkg::OFF_W-1:3];
          bofs_d   = desc_rdata.offset[2:0];
          wid_d    = wclamp;
          up_d     = desc_rdata.mode == pfse_pkg::MODE_INC;
          nbytes_d = pfse_pkg::byte_span(desc_rdata.offset[2:0], wclamp);
          slot_d   = '0;
          state_d  = pfse_pkg::ST_FLD_RD;
        end
      end
      pfse_pkg::ST_FLD_RD: begin
        pkt_re    = fidx_ok;
        pend_d    = 1'b1;
        pend_ok_d = fidx_ok;
        slot_d    = slot_q + 1'b1;
        if (slot_q == pfse_pkg::SLOT_LAST) begin
          state_d = pfse_pkg::ST_FLD_LAST;
        end
      end
      pfse_pkg::ST_FLD_LAST: begin
        state_d = pfse_pkg::ST_FLD_EXT;
      end
      pfse_pkg::ST_FLD_EXT: begin
        fu_ctrl.extract = 1'b1;
        state_d         = pfse_pkg::ST_FLD_STEP;
      end
      pfse_pkg::ST_FLD_STEP: begin
        fu_ctrl.step = 1'b1;
        state_d      = pfse_pkg::ST_FLD_MRG;
      end
      pfse_pkg::ST_FLD_MRG: begin
        fu_ctrl.merge = 1'b1;
        slot_d        = '0;
        state_d       = pfse_pkg::ST_FLD_WR;
      end
      pfse_pkg::ST_FLD_WR: begin
        pkt_we            = fidx_ok;
        fu_ctrl.shift_out = 1'b1;
        slot_d            = slot_q + 1'b1;
        if (slot_q + 1'b1 == nbytes_q) begin
          cnt_d   = cnt_q + 1'b1;
          entry_d = entry_q + 1'b1;
          state_d = pfse_pkg::ST_DESC_RD;
        end
      end
      default: begin
        state_d = pfse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfse_pkg::ST_IDLE;
      entry_q   <= '0;
      cnt_q     <= '0;
      slot_q    <= '0;
      pend_q    <= 1'b0;
      pend_ok_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      entry_q   <= entry_d;
      cnt_q     <= cnt_d;
      slot_q    <= slot_d;
      pend_q    <= pend_d;
      pend_ok_q <= pend_ok_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nbytes_q  <= nbytes_d;
    base_q    <= base_d;
    bofs_q    <= bofs_d;
    wid_q     <= wid_d;
    up_q      <= up_d;
    rbyte_q   <= rbyte_d;
    stepped_q <= stepped_d;
  end

  pfse_desc_mem u_desc_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (desc_we),
    .waddr_i (entry_index_i[pfse_pkg::TABLE_AW-1:0]),
    .wdata_i (desc_wdata),
    .re_i    (desc_re),
    .raddr_i (entry_q[pfse_pkg::TABLE_AW-1:0]),
    .rdata_o (desc_rdata)
  );

  pfse_pkt_mem u_pkt_mem (
    .clk_i   (clk_i),
    .we_i    (pkt_we),
    .waddr_i (pkt_waddr),
    .wdata_i (pkt_wdata),
    .re_i    (pkt_re),
    .raddr_i (pkt_raddr),
    .rdata_o (pkt_rdata)
  );

  pfse_field_unit u_field_unit (
    .clk_i  (clk_i),
    .ctrl_i (fu_ctrl),
    .byte_i (fu_byte_in),
    .byte_o (fu_byte_out)
  );

  assign busy             = state_q != pfse_pkg::ST_IDLE;
  assign done_o           = done_q;
  assign read_byte_o      = rbyte_q;
  assign fields_stepped_o = stepped_q;

endmodule

// ===== rtl/core/pfse_checker.sv =====
// port-level checks of the packet field step engine and their bind
`timescale 1ns / 1ps
module pfse_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 kind_i,
  input logic                       done_o,
  input logic [7:0]                 read_byte_o,
  input logic [pfse_pkg::CNT_W-1:0] fields_stepped_o
);

  // write transfers report a zero result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == pfse_pkg::KIND_WR_DESC ||
                        kind_i == pfse_pkg::KIND_WR_BYTE))
    |=> (done_o && !busy && read_byte_o == 8'h00 && fields_stepped_o == '0))
    else $error("write transfer result missing or nonzero");

  // byte read stays busy without a result, then reports with no step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == pfse_pkg::KIND_RD_BYTE)
    |=> (busy && !done_o) ##1 (done_o && !busy && fields_stepped_o == '0))
    else $error("byte read result timing wrong");

  // advance never reports in the cycle right after its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == pfse_pkg::KIND_ADVANCE) |=> (busy && !done_o))
    else $error("advance finished too early");

  // a result never carries both a read byte and a step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (read_byte_o == 8'h00 || fields_stepped_o == '0))
    else $error("result mixes read byte and step count");

  // step count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fields_stepped_o <= pfse_pkg::CNT_W'(pfse_pkg::TABLE_DEPTH)))
    else $error("step count out of range");

endmodule

bind packet_field_step_engine pfse_checker u_pfse_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .kind_i           (kind_i),
  .done_o           (done_o),
  .read_byte_o      (read_byte_o),
  .fields_stepped_o (fields_stepped_o)
);

// ===== verif/pfse_step_checker.sv =====
// checker for the packet field step engine: predicts each command's result and compares
`timescale 1ns / 1ps
module pfse_step_checker
  import pfse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       kind_i,
  input  logic [5:0]       entry_index_i,
  input  logic             entry_used_i,
  input  logic [OFF_W-1:0] field_bit_offset_i,
  input  logic [WID_W-1:0] field_bit_width_i,
  input  logic [1:0]       step_mode_i,
  input  logic [10:0]      byte_address_i,
  input  logic [7:0]       byte_value_i,
  input  logic             done_o,
  input  logic [7:0]       read_byte_o,
  input  logic [CNT_W-1:0] fields_stepped_o,
  output int               fail_count,
  output int               pending_count
);

  typedef struct {
    logic [7:0]       read_byte;
    logic [CNT_W-1:0] fields_stepped;
  } cmd_result_t;

  cmd_result_t expected_results[$];
  desc_t       field_table[TABLE_DEPTH];
  logic [7:0]  packet_mem[BUFFER_BYTES];

  // bits past the end of the buffer read as zero
  function automatic logic packet_bit(int unsigned pos);
    if ((pos >> 3) >= BUFFER_BYTES) return 1'b0;
    return packet_mem[pos >> 3][7 - (pos & 7)];
  endfunction

  // writes past the end of the buffer are dropped
  function automatic void set_packet_bit(int unsigned pos, logic v);
    if ((pos >> 3) < BUFFER_BYTES) packet_mem[pos >> 3][7 - (pos & 7)] = v;
  endfunction

  function automatic void bump_field(int unsigned ofs, int unsigned w, logic up);
    logic [63:0] val;
    logic [63:0] mask;
    val = '0;
    for (int unsigned i = 0; i < w; i++) begin
      if (packet_bit(ofs + i)) val[w - 1 - i] = 1'b1;
    end
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    val = up ? val + 64'd1 : val - 64'd1;
    val &= mask;
    for (int unsigned i = 0; i < w; i++) set_packet_bit(ofs + i, val[w - 1 - i]);
  endfunction

  function automatic cmd_result_t apply_command(
    kind_e k, logic [5:0] idx, logic used, logic [OFF_W-1:0] ofs, logic [WID_W-1:0] wid,
    logic [1:0] mode, logic [10:0] addr, logic [7:0] val);
    cmd_result_t r;
    int unsigned w;
    r.read_byte      = '0;
    r.fields_stepped = '0;
    case (k)
      KIND_WR_DESC: field_table[idx] = '{used: used, offset: ofs, width: wid, mode: mode};
      KIND_WR_BYTE: packet_mem[addr] = val;
      KIND_RD_BYTE: r.read_byte = packet_mem[addr];
      default: begin
        // walk from entry 0 until the first unused entry
        for (int e = 0; e < TABLE_DEPTH; e++) begin
          if (!field_table[e].used) break;
          w = (field_table[e].width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : field_table[e].width;
          if (w != 0 && (field_table[e].mode == MODE_INC || field_table[e].mode == MODE_DEC))
          begin
            bump_field(field_table[e].offset, w, field_table[e].mode == MODE_INC);
            r.fields_stepped = r.fields_stepped + 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_result_t exp_r;
    if (!rst_ni) begin
      foreach (field_table[e]) field_table[e] = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding: read_byte %0h fields_stepped %0d",
                 read_byte_o, fields_stepped_o);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (read_byte_o !== exp_r.read_byte) begin
            $error("read_byte: expected %0h, got %0h", exp_r.read_byte, read_byte_o);
            fail_count++;
          end
          if (fields_stepped_o !== exp_r.fields_stepped) begin
            $error("fields_stepped: expected %0d, got %0d", exp_r.fields_stepped,
                   fields_stepped_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_command(kind_e'(kind_i), entry_index_i,
          entry_used_i, field_bit_offset_i, field_bit_width_i, step_mode_i,
          byte_address_i, byte_value_i));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== verif/tb_packet_field_step_engine.sv =====
// testbench top for the packet field step engine: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_packet_field_step_engine;
  import pfse_pkg::*;

  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         PHASE_ITEMS    = 220;
  localparam int         LOW_BYTES      = 64;
  localparam int         LOW_OFS_MAX    = (LOW_BYTES - 9) * 8 + 7;
  localparam int         HIGH_BASE      = BUFFER_BYTES - 16;
  localparam logic [1:0] STEP_HOLD      = 2'd0;
  localparam logic [1:0] STEP_RSVD      = 2'd3;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       kind_i;
  logic [5:0]       entry_index_i;
  logic             entry_used_i;
  logic [OFF_W-1:0] field_bit_offset_i;
  logic [WID_W-1:0] field_bit_width_i;
  logic [1:0]       step_mode_i;
  logic [10:0]      byte_address_i;
  logic [7:0]       byte_value_i;
  logic             done_o;
  logic [7:0]       read_byte_o;
  logic [CNT_W-1:0] fields_stepped_o;

  int fail_count;
  int pending_count;
  int quiet_cycles;
  int sender_idle_pct;
  int kind_count[4];

  packet_field_step_engine uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .entry_index_i      (entry_index_i),
    .entry_used_i       (entry_used_i),
    .field_bit_offset_i (field_bit_offset_i),
    .field_bit_width_i  (field_bit_width_i),
    .step_mode_i        (step_mode_i),
    .byte_address_i     (byte_address_i),
    .byte_value_i       (byte_value_i),
    .done_o             (done_o),
    .read_byte_o        (read_byte_o),
    .fields_stepped_o   (fields_stepped_o)
  );

  pfse_step_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .entry_index_i      (entry_index_i),
    .entry_used_i       (entry_used_i),
    .field_bit_offset_i (field_bit_offset_i),
    .field_bit_width_i  (field_bit_width_i),
    .step_mode_i        (step_mode_i),
    .byte_address_i     (byte_address_i),
    .byte_value_i       (byte_value_i),
    .done_o             (done_o),
    .read_byte_o        (read_byte_o),
    .fields_stepped_o   (fields_stepped_o),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_packet_field_step_engine: errors");
      $finish;
    end
  end

  // one command transfer, then sender idle cycles
  task automatic push_cmd(kind_e k, logic [5:0] idx, logic used, logic [OFF_W-1:0] ofs,
                          logic [WID_W-1:0] wid, logic [1:0] mode, logic [10:0] addr,
                          logic [7:0] val);
    kind_i             <= k;
    entry_index_i      <= idx;
    entry_used_i       <= used;
    field_bit_offset_i <= ofs;
    field_bit_width_i  <= wid;
    step_mode_i        <= mode;
    byte_address_i     <= addr;
    byte_value_i       <= val;
    start              <= 1'b1;
    do @(posedge clk_i); while (busy);
    kind_count[k]++;
    while ($urandom_range(1, 100) <= sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic write_desc(logic [5:0] idx, logic used, logic [OFF_W-1:0] ofs,
                            logic [WID_W-1:0] wid, logic [1:0] mode);
    push_cmd(KIND_WR_DESC, idx, used, ofs, wid, mode, 11'($urandom), 8'($urandom));
  endtask

  task automatic write_packet(logic [10:0] addr, logic [7:0] val);
    push_cmd(KIND_WR_BYTE, 6'($urandom), 1'($urandom), 14'($urandom), 7'($urandom),
             2'($urandom), addr, val);
  endtask

  task automatic read_packet(logic [10:0] addr);
    push_cmd(KIND_RD_BYTE, 6'($urandom), 1'($urandom), 14'($urandom), 7'($urandom),
             2'($urandom), addr, 8'($urandom));
  endtask

  task automatic advance_fields();
    push_cmd(KIND_ADVANCE, 6'($urandom), 1'($urandom), 14'($urandom), 7'($urandom),
             2'($urandom), 11'($urandom), 8'($urandom));
  endtask

  // field windows stay inside the preloaded ends of the buffer or run past its end
  function automatic logic [OFF_W-1:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return OFF_W'($urandom_range(0, 255));
    if (r < 50) return OFF_W'($urandom_range(16300, 16383));
    return OFF_W'($urandom_range(0, LOW_OFS_MAX));
  endfunction

  function automatic logic [10:0] pick_addr();
    if ($urandom_range(0, 99) < 75) return 11'($urandom_range(0, LOW_BYTES - 1));
    return 11'($urandom_range(HIGH_BASE, BUFFER_BYTES - 1));
  endfunction

  function automatic logic [WID_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 18) return WID_W'($urandom_range(65, 127));
    if (r < 28) return WID_W'(MAX_FIELD_BITS);
    return WID_W'($urandom_range(1, 63));
  endfunction

  function automatic logic [1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return MODE_INC;
    if (r < 80) return MODE_DEC;
    if (r < 90) return STEP_HOLD;
    return STEP_RSVD;
  endfunction

  // a byte in or just past the span of a field
  function automatic logic [10:0] span_byte(logic [OFF_W-1:0] ofs);
    int unsigned a;
    a = (ofs >> 3) + $urandom_range(0, 8);
    return (a > BUFFER_BYTES - 1) ? 11'(BUFFER_BYTES - 1) : 11'(a);
  endfunction

  initial begin
    int               phase_idle[4];
    int               phase_base;
    int               n;
    int               r;
    logic [OFF_W-1:0] ofs_list[6];

    phase_idle = '{0, 51, 0, 20};
    sender_idle_pct = 0;
    rst_ni             <= 1'b0;
    start              <= 1'b0;
    kind_i             <= KIND_WR_DESC;
    entry_index_i      <= '0;
    entry_used_i       <= 1'b0;
    field_bit_offset_i <= '0;
    field_bit_width_i  <= '0;
    step_mode_i        <= STEP_HOLD;
    byte_address_i     <= '0;
    byte_value_i       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill both ends of the buffer; every read stays inside them, every field too unless it runs past the end
    for (int a = 0; a < LOW_BYTES; a++) write_packet(11'(a), 8'($urandom));
    for (int a = HIGH_BASE; a < BUFFER_BYTES; a++) write_packet(11'(a), 8'($urandom));

    // directed corners
    read_packet(11'd0);
    read_packet(11'(BUFFER_BYTES - 1));
    write_packet(11'd0, 8'hff);
    write_packet(11'(BUFFER_BYTES - 1), 8'h00);
    advance_fields();
    write_desc(6'd0, 1'b1, 14'd0, 7'd64, MODE_INC);
    write_desc(6'd1, 1'b1, 14'd16383, 7'd127, MODE_DEC);
    write_desc(6'd2, 1'b1, 14'd100, 7'd0, MODE_INC);
    write_desc(6'd3, 1'b1, 14'd40, 7'd8, STEP_RSVD);
    write_desc(6'd4, 1'b1, 14'd48, 7'd8, STEP_HOLD);
    write_desc(6'd5, 1'b1, 14'd7, 7'd1, MODE_DEC);
    write_desc(6'd6, 1'b0, 14'd16383, 7'd127, STEP_RSVD);
    write_desc(6'd7, 1'b1, 14'd8, 7'd8, MODE_INC);
    advance_fields();
    advance_fields();
    for (int a = 0; a < 9; a++) read_packet(11'(a));
    read_packet(11'(BUFFER_BYTES - 1));

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = phase_idle[ph];
      phase_base = kind_count.sum();
      while (kind_count.sum() - phase_base < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 76) begin
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++) begin
            ofs_list[i] = pick_offset();
            write_desc(6'(i), 1'b1, ofs_list[i], pick_width(), pick_mode());
          end
          write_desc(6'(n), 1'b0, 14'($urandom), 7'($urandom), 2'($urandom));
          repeat ($urandom_range(0, 2))
            write_packet(span_byte(ofs_list[$urandom_range(0, n - 1)]), 8'($urandom));
          repeat ($urandom_range(1, 3)) advance_fields();
          repeat ($urandom_range(1, 3)) read_packet(span_byte(ofs_list[$urandom_range(0, n - 1)]));
        end else if (r < 78) begin
          // whole table in use: the walk runs off the end
          for (int e = 0; e < TABLE_DEPTH; e++)
            write_desc(6'(e), 1'b1, pick_offset(), pick_width(), pick_mode());
          advance_fields();
          read_packet(pick_addr());
        end else begin
          repeat ($urandom_range(1, 6))
            push_cmd(kind_e'($urandom_range(0, 3)), 6'($urandom), 1'($urandom), pick_offset(),
                     7'($urandom), 2'($urandom), pick_addr(), 8'($urandom));
        end
      end
    end
    start <= 1'b0;

    @(negedge clk_i);
    wait (pending_count == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d descriptor writes, %0d byte writes, %0d byte reads, %0d advances",
             kind_count[KIND_WR_DESC], kind_count[KIND_WR_BYTE], kind_count[KIND_RD_BYTE],
             kind_count[KIND_ADVANCE]);
    $display("both buffer ends preloaded; sender idle in 0, 51, 0 and 20 percent of cycles");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_packet_field_step_engine: clean");
    end else begin
      $display("tb_packet_field_step_engine: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pfse_pkg.sv
rtl/core/pfse_desc_mem.sv
rtl/core/pfse_pkt_mem.sv
rtl/core/pfse_field_unit.sv
rtl/core/packet_field_step_engine.sv
rtl/core/pfse_checker.sv
verif/pfse_step_checker.sv
verif/tb_packet_field_step_engine.sv
